>>> sv/hrjp_pkg.sv
// Shared types, constants and decode functions for the HID report to joystick pin block.
package hrjp_pkg;

    // Number of keycode slots in a keyboard report, and the width they take.
    localparam int KEY_SLOT_COUNT = 6;
    localparam int KEY_SLOTS_W    = 8 * KEY_SLOT_COUNT;

    // Number of joystick lines and their bit positions in a level vector.
    localparam int LINE_COUNT = 5;
    localparam int LN_UP      = 0;
    localparam int LN_DOWN    = 1;
    localparam int LN_LEFT    = 2;
    localparam int LN_RIGHT   = 3;
    localparam int LN_FIRE    = 4;

    // Report kinds.
    localparam logic KIND_KBD = 1'b0;
    localparam logic KIND_PAD = 1'b1;

    // Stick geometry.
    localparam logic [7:0] STICK_CENTRE     = 8'd127;
    localparam logic [7:0] AXIS_MOVE_TOL    = 8'd2;
    localparam logic [6:0] STICK_MARGIN_RST = 7'd10;
    localparam logic [2:0] FIRE_BTN_MASK    = 3'b111;

    // Hat codes, clockwise from up.
    localparam logic [7:0] HAT_CENTRE     = 8'd0;
    localparam logic [7:0] HAT_UP         = 8'd1;
    localparam logic [7:0] HAT_UP_RIGHT   = 8'd2;
    localparam logic [7:0] HAT_RIGHT      = 8'd3;
    localparam logic [7:0] HAT_DOWN_RIGHT = 8'd4;
    localparam logic [7:0] HAT_DOWN       = 8'd5;
    localparam logic [7:0] HAT_DOWN_LEFT  = 8'd6;
    localparam logic [7:0] HAT_LEFT       = 8'd7;
    localparam logic [7:0] HAT_UP_LEFT    = 8'd8;

    // HID usage codes that drive a line.
    localparam logic [7:0] KEY_EMPTY  = 8'h00;
    localparam logic [7:0] KEY_KP0    = 8'h62;
    localparam logic [7:0] KEY_J      = 8'h0D;
    localparam logic [7:0] KEY_Z      = 8'h1D;
    localparam logic [7:0] KEY_KP8    = 8'h60;
    localparam logic [7:0] KEY_W      = 8'h1A;
    localparam logic [7:0] KEY_ARR_UP = 8'h52;
    localparam logic [7:0] KEY_KP6    = 8'h5E;
    localparam logic [7:0] KEY_D      = 8'h07;
    localparam logic [7:0] KEY_ARR_RT = 8'h4F;
    localparam logic [7:0] KEY_KP5    = 8'h5D;
    localparam logic [7:0] KEY_KP2    = 8'h5A;
    localparam logic [7:0] KEY_S      = 8'h16;
    localparam logic [7:0] KEY_ARR_DN = 8'h51;
    localparam logic [7:0] KEY_KP4    = 8'h5C;
    localparam logic [7:0] KEY_A      = 8'h04;
    localparam logic [7:0] KEY_ARR_LT = 8'h50;

    typedef logic [LINE_COUNT-1:0] t_lines;

    // One report as held in the input register.
    typedef struct packed {
        logic                   kind;
        logic [KEY_SLOTS_W-1:0] key_slots;
        logic [7:0]             axis_x;
        logic [7:0]             axis_y;
        logic [7:0]             axis_z;
        logic [7:0]             axis_rz;
        logic [7:0]             hat;
        logic [31:0]            buttons;
    } t_report;

    // Gamepad evaluation result handed back to the top level.
    typedef struct packed {
        logic   changed;
        t_lines levels;
    } t_pad_res;

    // Maps a keycode to a one-hot line mask, or zero when the key is unmapped.
    function automatic t_lines line_of_key(input logic [7:0] code);
        t_lines m;
        m = '0;
        case (code)
            KEY_KP0, KEY_J, KEY_Z:                 m[LN_FIRE]  = 1'b1;
            KEY_KP8, KEY_W, KEY_ARR_UP:            m[LN_UP]    = 1'b1;
            KEY_KP6, KEY_D, KEY_ARR_RT:            m[LN_RIGHT] = 1'b1;
            KEY_KP5, KEY_KP2, KEY_S, KEY_ARR_DN:   m[LN_DOWN]  = 1'b1;
            KEY_KP4, KEY_A, KEY_ARR_LT:            m[LN_LEFT]  = 1'b1;
            default:                               m = '0;
        endcase
        return m;
    endfunction

    // True when two axis bytes differ by more than the movement tolerance.
    function automatic logic far_apart(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d > AXIS_MOVE_TOL;
    endfunction

endpackage

>>> sv/hrjp_if.sv
// Valid/ready channel interfaces for report beats in and pin level beats out.
interface hrjp_in_if
    import hrjp_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [KEY_SLOTS_W-1:0] key_slots;
    logic [7:0]             axis_x;
    logic [7:0]             axis_y;
    logic [7:0]             axis_z;
    logic [7:0]             axis_rz;
    logic [7:0]             hat;
    logic [31:0]            buttons;

    modport source (
        output valid, kind, key_slots, axis_x, axis_y, axis_z, axis_rz, hat, buttons,
        input  ready
    );
    modport sink (
        input  valid, kind, key_slots, axis_x, axis_y, axis_z, axis_rz, hat, buttons,
        output ready
    );
endinterface

interface hrjp_out_if
    import hrjp_pkg::*;
();
    logic valid;
    logic ready;
    logic up_line;
    logic down_line;
    logic left_line;
    logic right_line;
    logic fire_line;

    modport source (
        output valid, up_line, down_line, left_line, right_line, fire_line,
        input  ready
    );
    modport sink (
        input  valid, up_line, down_line, left_line, right_line, fire_line,
        output ready
    );
endinterface

>>> sv/hrjp_kbd.sv
// Keyboard report evaluation: press and release masks against the previous report.
module hrjp_kbd
    import hrjp_pkg::*;
(
    input  logic [KEY_SLOTS_W-1:0] i_cur_slots,
    input  logic [KEY_SLOTS_W-1:0] i_last_slots,
    input  t_lines                 i_levels,
    output t_lines                 o_levels
);

    t_lines press;
    t_lines release_mask;

    // Each slot is checked against every slot of the other report.
    always_comb begin
        logic [7:0] kc;
        logic [7:0] kl;
        logic       cur_in_last;
        logic       last_in_cur;
        press        = '0;
        release_mask = '0;
        for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
            kc          = i_cur_slots[8*i +: 8];
            kl          = i_last_slots[8*i +: 8];
            cur_in_last = 1'b0;
            last_in_cur = 1'b0;
            for (int j = 0; j < KEY_SLOT_COUNT; j++) begin
                if (i_last_slots[8*j +: 8] == kc) begin
                    cur_in_last = 1'b1;
                end
                if (i_cur_slots[8*j +: 8] == kl) begin
                    last_in_cur = 1'b1;
                end
            end
            if (kc != KEY_EMPTY && !cur_in_last) begin
                press = press | line_of_key(kc);
            end
            if (!last_in_cur) begin
                release_mask = release_mask | line_of_key(kl);
            end
        end
    end

    // Presses pull low first, then releases win.
    assign o_levels = (i_levels & ~press) | release_mask;

endmodule

>>> sv/hrjp_pad.sv
// Gamepad report evaluation: change test, stick with dead zone, hat override and fire.
module hrjp_pad
    import hrjp_pkg::*;
(
    input  t_report    i_rep,
    input  logic [31:0] i_last_axes,
    input  logic [7:0]  i_last_hat,
    input  logic [31:0] i_last_buttons,
    input  logic [6:0]  i_stick_margin,
    input  t_lines      i_levels,
    output t_pad_res    o_res
);

    logic [7:0] hi;
    logic [7:0] lo;
    logic       changed;

    // Thresholds either side of the centre; the dead zone never exceeds the centre.
    assign hi = STICK_CENTRE + {1'b0, i_stick_margin};
    assign lo = STICK_CENTRE - {1'b0, i_stick_margin};

    // A report counts only when an axis moved noticeably or the hat or buttons changed.
    assign changed = far_apart(i_rep.axis_x,  i_last_axes[7:0])   ||
                     far_apart(i_rep.axis_y,  i_last_axes[15:8])  ||
                     far_apart(i_rep.axis_z,  i_last_axes[23:16]) ||
                     far_apart(i_rep.axis_rz, i_last_axes[31:24]) ||
                     (i_rep.hat != i_last_hat) ||
                     (i_rep.buttons != i_last_buttons);

    // New levels, applied by the top level only when the report changed.
    always_comb begin
        t_lines lv;
        lv = i_levels;
        if (i_rep.axis_rz == STICK_CENTRE) begin
            lv[LN_UP]   = 1'b1;
            lv[LN_DOWN] = 1'b1;
        end
        if (i_rep.axis_rz > hi) begin
            lv[LN_DOWN] = 1'b0;
        end
        if (i_rep.axis_rz < lo) begin
            lv[LN_UP] = 1'b0;
        end
        lv[LN_RIGHT] = !(i_rep.axis_z > hi);
        lv[LN_LEFT]  = !(i_rep.axis_z < lo);

        // A valid hat code overrides all four directions.
        case (i_rep.hat)
            HAT_CENTRE: begin
                lv[LN_UP] = 1'b1; lv[LN_RIGHT] = 1'b1; lv[LN_DOWN] = 1'b1; lv[LN_LEFT] = 1'b1;
            end
            HAT_UP: begin
                lv[LN_UP] = 1'b0; lv[LN_RIGHT] = 1'b1; lv[LN_DOWN] = 1'b1; lv[LN_LEFT] = 1'b1;
            end
            HAT_UP_RIGHT: begin
                lv[LN_UP] = 1'b0; lv[LN_RIGHT] = 1'b0; lv[LN_DOWN] = 1'b1; lv[LN_LEFT] = 1'b1;
            end
            HAT_RIGHT: begin
                lv[LN_UP] = 1'b1; lv[LN_RIGHT] = 1'b0; lv[LN_DOWN] = 1'b1; lv[LN_LEFT] = 1'b1;
            end
            HAT_DOWN_RIGHT: begin
                lv[LN_UP] = 1'b1; lv[LN_RIGHT] = 1'b0; lv[LN_DOWN] = 1'b0; lv[LN_LEFT] = 1'b1;
            end
            HAT_DOWN: begin
                lv[LN_UP] = 1'b1; lv[LN_RIGHT] = 1'b1; lv[LN_DOWN] = 1'b0; lv[LN_LEFT] = 1'b1;
            end
            HAT_DOWN_LEFT: begin
                lv[LN_UP] = 1'b1; lv[LN_RIGHT] = 1'b1; lv[LN_DOWN] = 1'b0; lv[LN_LEFT] = 1'b0;
            end
            HAT_LEFT: begin
                lv[LN_UP] = 1'b1; lv[LN_RIGHT] = 1'b1; lv[LN_DOWN] = 1'b1; lv[LN_LEFT] = 1'b0;
            end
            HAT_UP_LEFT: begin
                lv[LN_UP] = 1'b0; lv[LN_RIGHT] = 1'b1; lv[LN_DOWN] = 1'b1; lv[LN_LEFT] = 1'b0;
            end
            default: begin
                lv = lv;
            end
        endcase

        // Fire follows the first three buttons.
        lv[LN_FIRE] = !((i_rep.buttons[2:0] & FIRE_BTN_MASK) != 3'b000);
        o_res.changed = changed;
        o_res.levels  = lv;
    end

endmodule

>>> sv/hid_report_to_joystick_pins_core.sv
// Top level of the HID report to joystick pin block: registers, handshake and state.
//
// Each accepted report beat yields exactly one beat of five active-low line levels.
// A beat is taken into an input register and evaluated against the stored previous
// reports once the result register is free or being emptied; the new levels then land
// in the result register, which offers them as the result beat. One report
// is accepted every cycle as long as the result side takes its beats; the single compare
// stage between the input and result registers sets that rate. The dead zone register
// may be written at any time the block holds no report; it resets to 10.
module hid_report_to_joystick_pins_core
    import hrjp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrjp_in_if.sink    i_rep,
    hrjp_out_if.source o_pins,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata
);

    logic                   r_in_valid;
    t_report                r_in;
    logic                   r_out_valid;
    t_lines                 r_lines;
    logic [KEY_SLOTS_W-1:0] r_last_kbd;
    logic [31:0]            r_last_axes;
    logic [7:0]             r_last_hat;
    logic [31:0]            r_last_buttons;
    logic [6:0]             r_stick_margin;

    logic     w_adv;
    t_lines   w_kbd_levels;
    t_pad_res w_pad_res;
    t_lines   n_lines;

    // The input stage moves on when the result register is free or being emptied.
    assign w_adv       = r_in_valid && (!r_out_valid || o_pins.ready);
    assign i_rep.ready = !r_in_valid || w_adv;

    hrjp_kbd u_kbd (
        .i_cur_slots  (r_in.key_slots),
        .i_last_slots (r_last_kbd),
        .i_levels     (r_lines),
        .o_levels     (w_kbd_levels)
    );

    hrjp_pad u_pad (
        .i_rep          (r_in),
        .i_last_axes    (r_last_axes),
        .i_last_hat     (r_last_hat),
        .i_last_buttons (r_last_buttons),
        .i_stick_margin (r_stick_margin),
        .i_levels       (r_lines),
        .o_res          (w_pad_res)
    );

    // Select the level update for the report kind.
    always_comb begin
        if (r_in.kind == KIND_KBD) begin
            n_lines = w_kbd_levels;
        end else if (w_pad_res.changed) begin
            n_lines = w_pad_res.levels;
        end else begin
            n_lines = r_lines;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rep.ready) begin
            r_in_valid <= i_rep.valid;
        end
        if (i_rep.ready && i_rep.valid) begin
            r_in.kind      <= i_rep.kind;
            r_in.key_slots <= i_rep.key_slots;
            r_in.axis_x    <= i_rep.axis_x;
            r_in.axis_y    <= i_rep.axis_y;
            r_in.axis_z    <= i_rep.axis_z;
            r_in.axis_rz   <= i_rep.axis_rz;
            r_in.hat       <= i_rep.hat;
            r_in.buttons   <= i_rep.buttons;
        end
    end

    // Result register and stored report history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_lines        <= '1;
            r_last_kbd     <= '0;
            r_last_axes    <= '0;
            r_last_hat     <= '0;
            r_last_buttons <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_lines     <= n_lines;
                if (r_in.kind == KIND_KBD) begin
                    r_last_kbd <= r_in.key_slots;
                end else begin
                    r_last_axes    <= {r_in.axis_rz, r_in.axis_z, r_in.axis_y, r_in.axis_x};
                    r_last_hat     <= r_in.hat;
                    r_last_buttons <= r_in.buttons;
                end
            end else if (o_pins.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Dead zone configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick_margin <= STICK_MARGIN_RST;
        end else if (i_cfg_we) begin
            r_stick_margin <= i_cfg_wdata;
        end
    end

    // The result beat always carries the current line levels.
    assign o_pins.valid      = r_out_valid;
    assign o_pins.up_line    = r_lines[LN_UP];
    assign o_pins.down_line  = r_lines[LN_DOWN];
    assign o_pins.left_line  = r_lines[LN_LEFT];
    assign o_pins.right_line = r_lines[LN_RIGHT];
    assign o_pins.fire_line  = r_lines[LN_FIRE];

`ifndef ASSERT_OFF
    // Reset releases every line.
    a_reset_released: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_lines == '1))
        else $error("lines not released after reset");

    // A report leaving the input stage always produces a result beat.
    a_adv_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("evaluated report produced no result beat");

    // A repeated keyboard report leaves the lines as they were.
    a_kbd_repeat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.kind == KIND_KBD && r_in.key_slots == r_last_kbd)
        |=> (r_lines == $past(r_lines)))
        else $error("unchanged keyboard report moved a line");

    // A gamepad report that fails the change test leaves the lines as they were.
    a_pad_still_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in.kind == KIND_PAD && !w_pad_res.changed)
        |=> (r_lines == $past(r_lines)))
        else $error("unchanged gamepad report moved a line");
`endif

endmodule
